>>> src/nbgs_pkg.sv
package nbgs_pkg;

   // Body slots held in the ring of cells.
   localparam int MAX_BODIES = 16;
   localparam int IDX_W = $clog2(MAX_BODIES);
   localparam int SH_W = $clog2(MAX_BODIES + 1);
   localparam int CNT_W = 5;
   // Bodies in use never exceed the slot count nor sixteen.
   localparam int N_LIMIT = (MAX_BODIES < 16) ? MAX_BODIES : 16;
   // Velocity plus up to fifteen saturated pulls, summed exactly.
   localparam int ACC_W = 37;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_GRAVITY = 1'b0;
   localparam logic [0:0] CSR_BODIES = 1'b1;
   localparam logic [31:0] GRAVITY_RESET = 32'h0100_0000;
   localparam logic [4:0] BODIES_RESET = 5'd16;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [31:0] mass;
      logic [2:0][ACC_W-1:0] acc;
   } body_type;

   typedef struct packed {
      logic done;
      logic [2:0][ACC_W-1:0] contrib;
   } pair_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_PROBE,
      ST_SCAN,
      ST_WAIT,
      ST_ALIGN,
      ST_EMIT,
      ST_RETURN
   } step_state_type;

   typedef enum logic [3:0] {
      PU_IDLE,
      PU_ABS,
      PU_SQUARE,
      PU_SUM,
      PU_SQRT,
      PU_CUBE1,
      PU_CUBE2,
      PU_COMBINE,
      PU_CHECK,
      PU_DIV,
      PU_FINISH
   } pair_state_type;

   function automatic logic [31:0] sat_acc(input logic [ACC_W-1:0] v);
      logic [31:0] r;
      if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
         r = v[31:0];
      end else if (v[ACC_W-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_pos(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] == v[31]) begin
         r = v[31:0];
      end else if (v[32]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

>>> src/nbody_gravity_euler_step_unit.sv
// Gravitational N-body step engine. A load word writes one body slot.
// A step word kicks every body in use with the pull of all others, moves it, and then
// emits one result word per body in index order with the last one flagged. The bodies
// sit in a ring of cells that rotates past a single iterative pair unit; each ordered
// pair holds the ring there while the unit works out a square root and a division,
// and the result side may stall the output run. No word is accepted while a step runs.
module nbody_gravity_euler_step_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [3:0]                      req_body_index,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic signed [31:0]              req_pos_z,
   input  logic signed [31:0]              req_vel_x,
   input  logic signed [31:0]              req_vel_y,
   input  logic signed [31:0]              req_vel_z,
   input  logic [31:0]                     req_body_mass,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [3:0]                      rsp_out_index,
   output logic signed [31:0]              rsp_new_pos_x,
   output logic signed [31:0]              rsp_new_pos_y,
   output logic signed [31:0]              rsp_new_pos_z,
   output logic signed [31:0]              rsp_new_vel_x,
   output logic signed [31:0]              rsp_new_vel_y,
   output logic signed [31:0]              rsp_new_vel_z,
   output logic                            rsp_last_body,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nbgs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = nbgs_pkg::IDX_W;
   localparam int SH_W = nbgs_pkg::SH_W;
   localparam int CNT_W = nbgs_pkg::CNT_W;

   nbgs_pkg::step_state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in, head_next;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic [SH_W-1:0] shifts_ff, shifts_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [2:0][31:0] probe_pos_ff, probe_pos_in;
   logic [31:0] probe_mass_ff, probe_mass_in;
   logic [31:0] gravity_ff, gravity_in;
   logic [4:0] bodies_ff, bodies_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_index_ff, rsp_index_in;
   logic [2:0][31:0] rsp_pos_ff, rsp_pos_in;
   logic [2:0][31:0] rsp_vel_ff, rsp_vel_in;
   logic rsp_last_ff, rsp_last_in;

   nbgs_pkg::body_type ring [nbgs_pkg::MAX_BODIES];
   nbgs_pkg::body_type head;
   nbgs_pkg::body_type ret_body;
   nbgs_pkg::body_type load_data;
   nbgs_pkg::pair_result_type pair_res;

   logic shift_en, init_en, pair_start, probe_load, out_load, load_accept;
   logic head_in_use;
   logic csr_write;
   logic [0:0] csr_index;
   logic [2:0][31:0] nv, np;

   assign head = ring[0];
   assign head_in_use = int'(head_ff) < int'(n_ff);
   assign head_next = (head_ff == IDX_W'(nbgs_pkg::MAX_BODIES - 1)) ? '0 : head_ff + 1'b1;

   // Register file.
   assign csr_index = csr_paddr[nbgs_pkg::CSR_ADDR_W-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == nbgs_pkg::CSR_BODIES) ? {27'd0, bodies_ff} : gravity_ff;

   always_comb begin
      gravity_in = gravity_ff;
      bodies_in = bodies_ff;
      if (csr_write) begin
         unique case (csr_index)
            nbgs_pkg::CSR_GRAVITY: gravity_in = csr_pwdata;
            nbgs_pkg::CSR_BODIES: bodies_in = csr_pwdata[4:0];
            default: gravity_in = gravity_ff;
         endcase
      end
   end

   assign req_stall = (state_ff != nbgs_pkg::ST_IDLE);
   assign load_accept = req_valid && !req_stall && (req_type == nbgs_pkg::REQ_LOAD) &&
                        (int'(req_body_index) < nbgs_pkg::MAX_BODIES);

   always_comb begin
      load_data = '0;
      load_data.pos = {req_pos_z, req_pos_y, req_pos_x};
      load_data.vel = {req_vel_z, req_vel_y, req_vel_x};
      load_data.mass = req_body_mass;
   end

   // Kick and drift of the head body as it is emitted.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         nv[c] = nbgs_pkg::sat_acc(head.acc[c]);
         np[c] = nbgs_pkg::sat_pos({head.pos[c][31], head.pos[c]} + {nv[c][31], nv[c]});
      end
   end

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      n_in = n_ff;
      shift_en = 1'b0;
      init_en = 1'b0;
      pair_start = 1'b0;
      probe_load = 1'b0;
      out_load = 1'b0;
      ret_body = head;

      unique case (state_ff)
         nbgs_pkg::ST_IDLE: begin
            if (req_valid && req_type == nbgs_pkg::REQ_STEP) begin
               if (bodies_ff == '0) begin
                  n_in = CNT_W'(1);
               end else if (int'(bodies_ff) > nbgs_pkg::N_LIMIT) begin
                  n_in = CNT_W'(nbgs_pkg::N_LIMIT);
               end else begin
                  n_in = bodies_ff;
               end
               state_in = nbgs_pkg::ST_INIT;
            end
         end
         nbgs_pkg::ST_INIT: begin
            init_en = 1'b1;
            pass_in = '0;
            state_in = nbgs_pkg::ST_PROBE;
         end
         nbgs_pkg::ST_PROBE: begin
            // The head cell holds the body whose pull this pass spreads to the others.
            probe_load = 1'b1;
            state_in = nbgs_pkg::ST_SCAN;
         end
         nbgs_pkg::ST_SCAN: begin
            if (shifts_ff == SH_W'(nbgs_pkg::MAX_BODIES)) begin
               // One extra shift brings the next source body to the head.
               shift_en = 1'b1;
               if (CNT_W'(pass_ff + 1'b1) == n_ff) begin
                  state_in = nbgs_pkg::ST_ALIGN;
               end else begin
                  pass_in = pass_ff + 1'b1;
                  state_in = nbgs_pkg::ST_PROBE;
               end
            end else if (head_in_use && int'(head_ff) != int'(pass_ff)) begin
               pair_start = 1'b1;
               state_in = nbgs_pkg::ST_WAIT;
            end else begin
               shift_en = 1'b1;
            end
         end
         nbgs_pkg::ST_WAIT: begin
            if (pair_res.done) begin
               for (int c = 0; c < 3; c++) begin
                  ret_body.acc[c] = head.acc[c] + pair_res.contrib[c];
               end
               shift_en = 1'b1;
               state_in = nbgs_pkg::ST_SCAN;
            end
         end
         nbgs_pkg::ST_ALIGN: begin
            if (head_ff == '0) begin
               state_in = nbgs_pkg::ST_EMIT;
            end else begin
               shift_en = 1'b1;
            end
         end
         nbgs_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               ret_body.pos = np;
               ret_body.vel = nv;
               shift_en = 1'b1;
               if (int'(head_ff) == int'(n_ff) - 1) begin
                  state_in = nbgs_pkg::ST_RETURN;
               end
            end
         end
         nbgs_pkg::ST_RETURN: begin
            if (head_ff == '0) begin
               state_in = nbgs_pkg::ST_IDLE;
            end else begin
               shift_en = 1'b1;
            end
         end
         default: begin
            state_in = nbgs_pkg::ST_IDLE;
         end
      endcase
   end

   assign head_in = shift_en ? head_next : head_ff;

   always_comb begin
      shifts_in = shifts_ff;
      if (probe_load) begin
         shifts_in = '0;
      end else if (shift_en) begin
         shifts_in = shifts_ff + 1'b1;
      end
   end

   always_comb begin
      probe_pos_in = probe_pos_ff;
      probe_mass_in = probe_mass_ff;
      if (probe_load) begin
         probe_pos_in = head.pos;
         probe_mass_in = head.mass;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      rsp_last_in = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = 4'(head_ff);
         rsp_pos_in = np;
         rsp_vel_in = nv;
         rsp_last_in = (int'(head_ff) == int'(n_ff) - 1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nbgs_pkg::ST_IDLE;
         head_ff <= '0;
         pass_ff <= '0;
         shifts_ff <= '0;
         n_ff <= CNT_W'(1);
         gravity_ff <= nbgs_pkg::GRAVITY_RESET;
         bodies_ff <= nbgs_pkg::BODIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         pass_ff <= pass_in;
         shifts_ff <= shifts_in;
         n_ff <= n_in;
         gravity_ff <= gravity_in;
         bodies_ff <= bodies_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_pos_ff <= probe_pos_in;
      probe_mass_ff <= probe_mass_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The ring: each cell hands its body to the one below, the head wraps to the top.
   for (genvar c = 0; c < nbgs_pkg::MAX_BODIES; c++) begin : g_cell
      nbgs_pkg::body_type shift_in;
      if (c == nbgs_pkg::MAX_BODIES - 1) begin : g_top
         assign shift_in = ret_body;
      end else begin : g_mid
         assign shift_in = ring[c + 1];
      end
      nbgs_cell u_cell (
         .clock     (clock),
         .load_en   (load_accept && int'(req_body_index) == c),
         .load_data (load_data),
         .init_en   (init_en),
         .shift_en  (shift_en),
         .shift_in  (shift_in),
         .q         (ring[c])
      );
   end

   nbgs_pair_unit u_pair (
      .clock    (clock),
      .reset    (reset),
      .start    (pair_start),
      .gravity  (gravity_ff),
      .src_pos  (probe_pos_ff),
      .src_mass (probe_mass_ff),
      .tgt_pos  (head.pos),
      .result   (pair_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_new_vel_x = rsp_vel_ff[0];
   assign rsp_new_vel_y = rsp_vel_ff[1];
   assign rsp_new_vel_z = rsp_vel_ff[2];
   assign rsp_last_body = rsp_last_ff;

endmodule

>>> src/nbgs_cell.sv
module nbgs_cell (
   input  logic              clock,
   input  logic              load_en,
   input  nbgs_pkg::body_type load_data,
   input  logic              init_en,
   input  logic              shift_en,
   input  nbgs_pkg::body_type shift_in,
   output nbgs_pkg::body_type q
);

   nbgs_pkg::body_type body_ff, body_in;

   always_comb begin
      body_in = body_ff;
      priority if (load_en) begin
         body_in = load_data;
      end else if (init_en) begin
         // The step starts each accumulator at the body's own velocity.
         for (int c = 0; c < 3; c++) begin
            body_in.acc[c] = {{(nbgs_pkg::ACC_W - 32){body_ff.vel[c][31]}}, body_ff.vel[c]};
         end
      end else if (shift_en) begin
         body_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   assign q = body_ff;

endmodule

>>> src/nbgs_pair_unit.sv
module nbgs_pair_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              gravity,
   input  logic [2:0][31:0]         src_pos,
   input  logic [31:0]              src_mass,
   input  logic [2:0][31:0]         tgt_pos,
   output nbgs_pkg::pair_result_type result
);

   localparam int SQRT_ITERS = 33;
   localparam int DIV_ITERS = 32;
   localparam int NUM_W = 121;
   localparam int DEN_W = 99;
   localparam int DIV_W = 131;

   nbgs_pkg::pair_state_type state_ff, state_in;
   logic [5:0] it_ff, it_in;
   logic [2:0][32:0] d_ff, d_in;
   logic [2:0][32:0] mag_ff, mag_in;
   logic [2:0] neg_ff, neg_in;
   logic [2:0][65:0] sq_ff, sq_in;
   logic [63:0] k_ff, k_in;
   logic [65:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic zero_ff, zero_in;
   logic [65:0] r2_ff, r2_in;
   logic [65:0] plo_ff, plo_in;
   logic [65:0] phi_ff, phi_in;
   logic [2:0][64:0] nlo_ff, nlo_in;
   logic [2:0][64:0] nhi_ff, nhi_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [2:0][NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] dv_ff, dv_in;
   logic [2:0] ovf_ff, ovf_in;
   logic [2:0][31:0] q_ff, q_in;
   nbgs_pkg::pair_result_type result_ff, result_in;

   always_comb begin
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic [65:0] sum;
      logic [31:0] lim;
      logic [31:0] qs;
      logic [nbgs_pkg::ACC_W-1:0] mag_acc;

      state_in = state_ff;
      it_in = it_ff;
      d_in = d_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      sq_in = sq_ff;
      k_in = k_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      zero_in = zero_ff;
      r2_in = r2_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      nlo_in = nlo_ff;
      nhi_in = nhi_ff;
      den_in = den_ff;
      num_in = num_ff;
      dv_in = dv_ff;
      ovf_in = ovf_ff;
      q_in = q_ff;
      result_in = result_ff;
      result_in.done = 1'b0;
      rem_sh = '0;
      trial = '0;
      sum = '0;
      lim = '0;
      qs = '0;
      mag_acc = '0;

      unique case (state_ff)
         nbgs_pkg::PU_IDLE: begin
            if (start) begin
               for (int c = 0; c < 3; c++) begin
                  d_in[c] = {src_pos[c][31], src_pos[c]} - {tgt_pos[c][31], tgt_pos[c]};
               end
               state_in = nbgs_pkg::PU_ABS;
            end
         end
         nbgs_pkg::PU_ABS: begin
            for (int c = 0; c < 3; c++) begin
               neg_in[c] = d_ff[c][32];
               mag_in[c] = d_ff[c][32] ? (~d_ff[c] + 33'd1) : d_ff[c];
            end
            state_in = nbgs_pkg::PU_SQUARE;
         end
         nbgs_pkg::PU_SQUARE: begin
            for (int c = 0; c < 3; c++) begin
               sq_in[c] = 66'(mag_ff[c]) * 66'(mag_ff[c]);
            end
            k_in = 64'(gravity) * 64'(src_mass);
            state_in = nbgs_pkg::PU_SUM;
         end
         nbgs_pkg::PU_SUM: begin
            sum = sq_ff[0] + sq_ff[1] + sq_ff[2];
            rad_in = sum;
            rem_in = '0;
            root_in = '0;
            it_in = '0;
            zero_in = (sum == '0);
            // Coincident bodies pull nothing, so the square root and the divider are skipped.
            state_in = (sum == '0) ? nbgs_pkg::PU_FINISH : nbgs_pkg::PU_SQRT;
         end
         nbgs_pkg::PU_SQRT: begin
            rem_sh = {rem_ff[33:0], rad_ff[65:64]};
            trial = {root_ff[33:0], 2'b01};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[32:0], 1'b0};
            end
            rad_in = {rad_ff[63:0], 2'b00};
            it_in = it_ff + 6'd1;
            if (it_ff == 6'(SQRT_ITERS - 1)) begin
               state_in = nbgs_pkg::PU_CUBE1;
            end
         end
         nbgs_pkg::PU_CUBE1: begin
            r2_in = 66'(root_ff[32:0]) * 66'(root_ff[32:0]);
            state_in = nbgs_pkg::PU_CUBE2;
         end
         nbgs_pkg::PU_CUBE2: begin
            plo_in = 66'(r2_ff[32:0]) * 66'(root_ff[32:0]);
            phi_in = 66'(r2_ff[65:33]) * 66'(root_ff[32:0]);
            for (int c = 0; c < 3; c++) begin
               nlo_in[c] = 65'(k_ff[31:0]) * 65'(mag_ff[c]);
               nhi_in[c] = 65'(k_ff[63:32]) * 65'(mag_ff[c]);
            end
            state_in = nbgs_pkg::PU_COMBINE;
         end
         nbgs_pkg::PU_COMBINE: begin
            den_in = DEN_W'(plo_ff) + (DEN_W'(phi_ff) << 33);
            for (int c = 0; c < 3; c++) begin
               num_in[c] = (NUM_W'(nlo_ff[c]) + (NUM_W'(nhi_ff[c]) << 32)) << 24;
            end
            state_in = nbgs_pkg::PU_CHECK;
         end
         nbgs_pkg::PU_CHECK: begin
            // A quotient of 2^32 or more saturates, so only 32 bits are divided out.
            for (int c = 0; c < 3; c++) begin
               ovf_in[c] = DIV_W'(num_ff[c]) >= (DIV_W'(den_ff) << 32);
               q_in[c] = '0;
            end
            dv_in = DIV_W'(den_ff) << 31;
            it_in = '0;
            state_in = nbgs_pkg::PU_DIV;
         end
         nbgs_pkg::PU_DIV: begin
            for (int c = 0; c < 3; c++) begin
               if (DIV_W'(num_ff[c]) >= dv_ff) begin
                  num_in[c] = NUM_W'(DIV_W'(num_ff[c]) - dv_ff);
                  q_in[c] = {q_ff[c][30:0], 1'b1};
               end else begin
                  q_in[c] = {q_ff[c][30:0], 1'b0};
               end
            end
            dv_in = dv_ff >> 1;
            it_in = it_ff + 6'd1;
            if (it_ff == 6'(DIV_ITERS - 1)) begin
               state_in = nbgs_pkg::PU_FINISH;
            end
         end
         nbgs_pkg::PU_FINISH: begin
            for (int c = 0; c < 3; c++) begin
               lim = neg_ff[c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               qs = (ovf_ff[c] || q_ff[c] > lim) ? lim : q_ff[c];
               mag_acc = nbgs_pkg::ACC_W'(qs);
               if (zero_ff) begin
                  result_in.contrib[c] = '0;
               end else begin
                  result_in.contrib[c] = neg_ff[c] ? (~mag_acc + 1'b1) : mag_acc;
               end
            end
            result_in.done = 1'b1;
            state_in = nbgs_pkg::PU_IDLE;
         end
         default: begin
            state_in = nbgs_pkg::PU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nbgs_pkg::PU_IDLE;
         result_ff.done <= 1'b0;
      end else begin
         state_ff <= state_in;
         result_ff.done <= result_in.done;
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      d_ff <= d_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      sq_ff <= sq_in;
      k_ff <= k_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      zero_ff <= zero_in;
      r2_ff <= r2_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      nlo_ff <= nlo_in;
      nhi_ff <= nhi_in;
      den_ff <= den_in;
      num_ff <= num_in;
      dv_ff <= dv_in;
      ovf_ff <= ovf_in;
      q_ff <= q_in;
      result_ff.contrib <= result_in.contrib;
   end

   assign result = result_ff;

endmodule

>>> src/nbgs_checker.sv
module nbgs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_type,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [3:0]        rsp_out_index,
   input logic signed [31:0] rsp_new_pos_x,
   input logic              rsp_last_body
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_index) &&
      $stable(rsp_new_pos_x))
      else $error("stalled result word changed");

   // While a step is still emitting, no new word is taken.
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_body |-> req_stall)
      else $error("input taken in the middle of a step's output run");

   // A load leaves the block ready for the next word.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == nbgs_pkg::REQ_LOAD |=> !req_stall)
      else $error("load did not return to idle");

   // Bodies come out in index order without gaps.
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_body |=>
      !rsp_valid || rsp_out_index == $past(rsp_out_index) + 4'd1)
      else $error("result index out of order");

endmodule

bind nbody_gravity_euler_step_unit nbgs_checker u_checker (.*);
